// ===== rtl/tai_pkg.sv =====
// Shared types, constants and lookup-table functions for the turret aim interpolator
package tai_pkg;

   // field widths
   localparam int CAM_W   = 16;
   localparam int POS_W   = 24;
   localparam int RATE_W  = 10;
   localparam int GAIN_W  = 16;
   localparam int ANGLE_W = 16;
   localparam int SPEED_W = 23;
   localparam int DRIVE_W = 10;
   localparam int MODE_W  = 2;

   // stream word layout
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 56;
   localparam int RSP_USED_W = DRIVE_W + ANGLE_W + SPEED_W;

   // pitch table: ascending ty points, angle and speed at each point (Q.8)
   localparam int TABLE_POINTS = 4;
   localparam int SEG_W        = 3;
   localparam int DTY_W        = 13;
   localparam int TGT_W        = 25;
   localparam int DIFF_W       = 21;
   localparam int DIV_W        = 14;

   localparam logic signed [CAM_W-1:0] TY_PTS [TABLE_POINTS] =
      '{-16'sd6267, -16'sd4618, -16'sd2148, 16'sd4045};
   localparam logic signed [TGT_W-1:0] ANGLE_PTS [TABLE_POINTS] =
      '{25'sd6523, 25'sd4815, 25'sd4078, 25'sd2683};
   localparam logic signed [TGT_W-1:0] SPEED_PTS [TABLE_POINTS] =
      '{25'sd4746752, 25'sd4174080, 25'sd3323904, 25'sd2816000};

   // floor(2^RECIP_SHIFT / (2*span)) for each segment
   localparam int RECIP_W     = 23;
   localparam int RECIP_SHIFT = 34;
   localparam logic [RECIP_W-1:0] SEG_RECIP [TABLE_POINTS-1] =
      '{23'd5209178, 23'd3477706, 23'd1387039};

   localparam int MAG_W  = 34;
   localparam int QEST_W = 23;
   localparam int Q_W    = 24;

   // shared multiplier
   localparam int MUL_A_W = 35;
   localparam int MUL_B_W = 24;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   // smoothing
   localparam int SMOOTH_DEPTH = 4;
   localparam int SMOOTH_SHIFT = 2;
   localparam logic [15:0]        SPEED_SCALE = 16'd62259;
   localparam logic [SPEED_W-1:0] SPEED_MAX   = 23'd8388607;

   // front-to-back queue, depth a power of two
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   localparam logic [MODE_W-1:0] MODE_FRAME = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ANGLE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SPEED = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0]        mode;
      logic signed [POS_W-1:0]  operand;
      logic                     use_track;
      logic                     yaw;
      logic                     pitch;
      logic signed [RATE_W-1:0] rate;
      logic [SEG_W-1:0]         seg;
      logic [DTY_W-1:0]         dty;
   } item_type;

   typedef struct packed {
      logic [GAIN_W-1:0]         gain_track;
      logic [GAIN_W-1:0]         gain_home;
      logic signed [ANGLE_W-1:0] angle_min;
      logic signed [ANGLE_W-1:0] angle_max;
   } cfg_type;

   typedef struct packed {
      logic signed [DRIVE_W-1:0] drive;
      logic                      rot_valid;
      logic signed [ANGLE_W-1:0] angle;
      logic [SPEED_W-1:0]        speed;
   } result_type;

   function automatic logic signed [TGT_W-1:0] point_val(input logic tbl,
                                                         input logic [SEG_W-1:0] idx);
      logic signed [TGT_W-1:0] v;
      v = '0;
      for (int i = 0; i < TABLE_POINTS; i++) begin
         if (idx == SEG_W'(i)) v = tbl ? SPEED_PTS[i] : ANGLE_PTS[i];
      end
      return v;
   endfunction

   function automatic logic signed [DIFF_W-1:0] seg_diff(input logic tbl,
                                                         input logic [SEG_W-1:0] seg);
      logic signed [DIFF_W-1:0] v;
      v = '0;
      for (int i = 1; i < TABLE_POINTS; i++) begin
         if (seg == SEG_W'(i)) begin
            v = tbl ? DIFF_W'(SPEED_PTS[i] - SPEED_PTS[i-1])
                    : DIFF_W'(ANGLE_PTS[i] - ANGLE_PTS[i-1]);
         end
      end
      return v;
   endfunction

   // twice the ty span of a segment
   function automatic logic [DIV_W-1:0] seg_div2(input logic [SEG_W-1:0] seg);
      logic [DIV_W-1:0] v;
      v = '0;
      for (int i = 1; i < TABLE_POINTS; i++) begin
         if (seg == SEG_W'(i)) v = DIV_W'((CAM_W + 1)'(TY_PTS[i]) - (CAM_W + 1)'(TY_PTS[i-1])) << 1;
      end
      return v;
   endfunction

   function automatic logic [RECIP_W-1:0] seg_recip(input logic [SEG_W-1:0] seg);
      logic [RECIP_W-1:0] v;
      v = '0;
      for (int i = 1; i < TABLE_POINTS; i++) begin
         if (seg == SEG_W'(i)) v = SEG_RECIP[i-1];
      end
      return v;
   endfunction

endpackage

// ===== rtl/tai_front.sv =====
// Input side: unpack request words, pick the drive operand and find the ty segment
module tai_front import tai_pkg::*; (
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [MODE_W-1:0]     req_tuser,
   input  logic                  queue_full,
   output logic                  push,
   output item_type              push_item
);

   logic signed [CAM_W-1:0]  tx;
   logic signed [CAM_W-1:0]  ty;
   logic                     seen;
   logic signed [POS_W-1:0]  pos;
   logic [SEG_W-1:0]         seg;
   logic [DTY_W-1:0]         dty;

   assign tx   = req_tdata[15:0];
   assign ty   = req_tdata[31:16];
   assign seen = req_tdata[32];
   assign pos  = req_tdata[56:33];

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   // segment is the first point above ty, TABLE_POINTS when beyond the last
   always_comb begin
      seg = SEG_W'(TABLE_POINTS);
      for (int i = TABLE_POINTS - 1; i >= 0; i--) begin
         if (ty < TY_PTS[i]) seg = SEG_W'(i);
      end
      dty = '0;
      for (int i = 1; i < TABLE_POINTS; i++) begin
         if (seg == SEG_W'(i)) dty = DTY_W'(ty - TY_PTS[i-1]);
      end
   end

   always_comb begin
      push_item.mode      = req_tuser;
      push_item.operand   = seen ? POS_W'(tx) : pos;
      push_item.use_track = seen;
      push_item.yaw       = req_tdata[57];
      push_item.pitch     = req_tdata[58];
      push_item.rate      = req_tdata[68:59];
      push_item.seg       = seg;
      push_item.dty       = dty;
   end

endmodule

// ===== rtl/tai_queue.sv =====
// Short queue of classified items between the front and back ends
module tai_queue import tai_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     empty,
   output item_type head
);

   item_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in;
   logic [QPTR_W-1:0]   rd_ff, rd_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;

   assign full  = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = slot_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_item;
   end

endmodule

// ===== rtl/tai_back.sv =====
// Execution side: sequencer around one shared multiplier, state update and result register
module tai_back import tai_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       q_empty,
   input  item_type   q_head,
   output logic       q_pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output result_type rsp_word
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_DRV   = 4'd1;
   localparam logic [3:0] ST_DRVC  = 4'd2;
   localparam logic [3:0] ST_LKN   = 4'd3;
   localparam logic [3:0] ST_LKQ   = 4'd4;
   localparam logic [3:0] ST_LKM   = 4'd5;
   localparam logic [3:0] ST_LKE   = 4'd6;
   localparam logic [3:0] ST_LKC   = 4'd7;
   localparam logic [3:0] ST_LKA   = 4'd8;
   localparam logic [3:0] ST_SMA   = 4'd9;
   localparam logic [3:0] ST_SMS   = 4'd10;
   localparam logic [3:0] ST_SMW   = 4'd11;
   localparam logic [3:0] ST_NUDGE = 4'd12;
   localparam logic [3:0] ST_DONE  = 4'd13;

   localparam int SS_W  = 27;
   localparam int SA_W  = 28;
   localparam int NA_W  = 18;
   localparam int NS_W  = 25;
   localparam int SPD_SHIFT = 16 + SMOOTH_SHIFT;

   localparam logic signed [PROD_W:0]   DRV_HALF = (PROD_W + 1)'(1) <<< (GAIN_W - 1);
   localparam logic signed [PROD_W:0]   DRV_HI   = (PROD_W + 1)'(256);
   localparam logic signed [PROD_W:0]   DRV_LO   = -(PROD_W + 1)'(256);
   localparam logic signed [PROD_W-1:0] SPD_HALF = PROD_W'(1) <<< (SPD_SHIFT - 1);
   localparam logic signed [PROD_W-1:0] SPD_TOP  = PROD_W'(SPEED_MAX);
   localparam logic signed [SA_W-1:0]   ANG_HI   = SA_W'(32767);
   localparam logic signed [SA_W-1:0]   ANG_LO   = -SA_W'(32768);
   localparam logic signed [NS_W-1:0]   NS_TOP   = NS_W'(SPEED_MAX);

   logic [3:0]                 state_ff, state_in;
   item_type                   item_ff, item_in;
   logic                       tbl_ff, tbl_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic [MAG_W-1:0]           mag_ff, mag_in;
   logic                       neg_ff, neg_in;
   logic [QEST_W-1:0]          qest_ff, qest_in;
   logic [Q_W-1:0]             q_ff, q_in;
   logic                       rnz_ff, rnz_in;
   logic signed [TGT_W-1:0]    ta_ff, ta_in;
   logic signed [TGT_W-1:0]    ts_ff, ts_in;
   logic signed [SS_W-1:0]     ss_ff, ss_in;
   logic signed [DRIVE_W-1:0]  drive_ff, drive_in;
   logic                       dvalid_ff, dvalid_in;
   logic signed [ANGLE_W-1:0]  angle_ff, angle_in;
   logic [SPEED_W-1:0]         speed_ff, speed_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   result_type                 rsp_word_ff, rsp_word_in;

   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic [GAIN_W-1:0]          gain;
   logic [DIV_W-1:0]           div2;
   logic signed [PROD_W:0]     drv_t;
   logic signed [PROD_W:0]     num;
   logic [MAG_W-1:0]           rem;
   logic [MAG_W-1:0]           rem_fix;
   logic                       rem_ge;
   logic signed [TGT_W-1:0]    qs;
   logic signed [TGT_W-1:0]    tgt;
   logic signed [SA_W-1:0]     sa;
   logic signed [PROD_W-1:0]   sp;
   logic signed [NA_W-1:0]     na;
   logic signed [NS_W-1:0]     ns;

   assign gain    = item_ff.use_track ? cfg.gain_track : cfg.gain_home;
   assign div2    = seg_div2(item_ff.seg);
   assign prod_in = mul_a * mul_b;

   assign q_pop      = (state_ff == ST_IDLE) && !q_empty;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_word   = rsp_word_ff;

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      tbl_in       = tbl_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      qest_in      = qest_ff;
      q_in         = q_ff;
      rnz_in       = rnz_ff;
      ta_in        = ta_ff;
      ts_in        = ts_ff;
      ss_in        = ss_ff;
      drive_in     = drive_ff;
      dvalid_in    = dvalid_ff;
      angle_in     = angle_ff;
      speed_in     = speed_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_word_in  = rsp_word_ff;
      mul_a        = '0;
      mul_b        = '0;
      drv_t        = '0;
      num          = '0;
      rem          = '0;
      rem_fix      = '0;
      rem_ge       = 1'b0;
      qs           = '0;
      tgt          = '0;
      sa           = '0;
      sp           = '0;
      na           = '0;
      ns           = '0;

      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               item_in   = q_head;
               tbl_in    = 1'b0;
               drive_in  = '0;
               dvalid_in = 1'b0;
               if (q_head.mode == MODE_FRAME) begin
                  if (q_head.yaw)        state_in = ST_DRV;
                  else if (q_head.pitch) state_in = ST_LKN;
                  else                   state_in = ST_DONE;
               end else begin
                  state_in = ST_NUDGE;
               end
            end
         end

         ST_DRV: begin
            mul_a    = MUL_A_W'($signed({1'b0, gain}));
            mul_b    = MUL_B_W'($signed(item_ff.operand));
            state_in = ST_DRVC;
         end

         ST_DRVC: begin
            // round -gain*x / 2^16, halves up, then clamp to one
            drv_t = DRV_HALF - (PROD_W + 1)'(prod_ff);
            drv_t = drv_t >>> GAIN_W;
            if (drv_t > DRV_HI)      drive_in = DRIVE_W'(DRV_HI);
            else if (drv_t < DRV_LO) drive_in = DRIVE_W'(DRV_LO);
            else                     drive_in = DRIVE_W'(drv_t);
            dvalid_in = 1'b1;
            state_in  = item_ff.pitch ? ST_LKN : ST_DONE;
         end

         ST_LKN: begin
            if (item_ff.seg == '0 || item_ff.seg == SEG_W'(TABLE_POINTS)) begin
               // flat beyond either end
               tgt = (item_ff.seg == '0) ? point_val(tbl_ff, '0)
                                          : point_val(tbl_ff, SEG_W'(TABLE_POINTS - 1));
               if (tbl_ff) ts_in = tgt;
               else        ta_in = tgt;
               tbl_in   = 1'b1;
               state_in = tbl_ff ? ST_SMA : ST_LKN;
            end else begin
               mul_a    = MUL_A_W'(seg_diff(tbl_ff, item_ff.seg));
               mul_b    = MUL_B_W'($signed({1'b0, item_ff.dty}));
               state_in = ST_LKQ;
            end
         end

         ST_LKQ: begin
            // numerator 2n + span; divide its magnitude by 2*span
            num = ((PROD_W + 1)'(prod_ff) <<< 1)
                + (PROD_W + 1)'($signed({1'b0, div2[DIV_W-1:1]}));
            neg_in   = num[PROD_W];
            mag_in   = num[PROD_W] ? MAG_W'(-num) : MAG_W'(num);
            state_in = ST_LKM;
         end

         ST_LKM: begin
            mul_a    = $signed({1'b0, mag_ff});
            mul_b    = $signed({1'b0, seg_recip(item_ff.seg)});
            state_in = ST_LKE;
         end

         ST_LKE: begin
            qest_in  = prod_ff[RECIP_SHIFT +: QEST_W];
            mul_a    = MUL_A_W'($signed({1'b0, prod_ff[RECIP_SHIFT +: QEST_W]}));
            mul_b    = MUL_B_W'($signed({1'b0, div2}));
            state_in = ST_LKC;
         end

         ST_LKC: begin
            // estimate is low by at most one
            rem     = mag_ff - prod_ff[MAG_W-1:0];
            rem_ge  = (rem >= MAG_W'(div2));
            rem_fix = rem_ge ? rem - MAG_W'(div2) : rem;
            q_in    = Q_W'(qest_ff) + Q_W'(rem_ge);
            rnz_in  = |rem_fix;
            state_in = ST_LKA;
         end

         ST_LKA: begin
            // floor of a negative quotient rounds the magnitude up
            qs  = neg_ff ? -(TGT_W'(q_ff) + TGT_W'(rnz_ff)) : TGT_W'(q_ff);
            tgt = point_val(tbl_ff, item_ff.seg - SEG_W'(1)) + qs;
            if (tbl_ff) ts_in = tgt;
            else        ta_in = tgt;
            tbl_in   = 1'b1;
            state_in = tbl_ff ? ST_SMA : ST_LKN;
         end

         ST_SMA: begin
            sa = SA_W'(angle_ff) * SA_W'(SMOOTH_DEPTH - 1) + SA_W'(ta_ff);
            sa = (sa + SA_W'(SMOOTH_DEPTH / 2)) >>> SMOOTH_SHIFT;
            if (sa > ANG_HI)      angle_in = ANGLE_W'(ANG_HI);
            else if (sa < ANG_LO) angle_in = ANGLE_W'(ANG_LO);
            else                  angle_in = ANGLE_W'(sa);
            ss_in = SS_W'($signed({1'b0, speed_ff})) * SS_W'(SMOOTH_DEPTH - 1)
                  + SS_W'(ts_ff);
            state_in = ST_SMS;
         end

         ST_SMS: begin
            mul_a    = MUL_A_W'(ss_ff);
            mul_b    = MUL_B_W'($signed({1'b0, SPEED_SCALE}));
            state_in = ST_SMW;
         end

         ST_SMW: begin
            sp = (prod_ff + SPD_HALF) >>> SPD_SHIFT;
            if (sp < 0)            speed_in = '0;
            else if (sp > SPD_TOP) speed_in = SPEED_MAX;
            else                   speed_in = SPEED_W'(sp);
            state_in = ST_DONE;
         end

         ST_NUDGE: begin
            case (item_ff.mode)
               MODE_ANGLE: begin
                  // upper limit first so that the lower one wins when crossed
                  na = NA_W'(angle_ff) + (NA_W'(item_ff.rate) <<< 1);
                  if (na > NA_W'(cfg.angle_max)) na = NA_W'(cfg.angle_max);
                  if (na < NA_W'(cfg.angle_min)) na = NA_W'(cfg.angle_min);
                  angle_in = ANGLE_W'(na);
               end
               MODE_SPEED: begin
                  ns = NS_W'($signed({1'b0, speed_ff})) + NS_W'(item_ff.rate) * NS_W'(100);
                  if (ns < 0)           speed_in = '0;
                  else if (ns > NS_TOP) speed_in = SPEED_MAX;
                  else                  speed_in = SPEED_W'(ns);
               end
               default: begin
               end
            endcase
            state_in = ST_DONE;
         end

         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in          = 1'b1;
               rsp_word_in.drive     = drive_ff;
               rsp_word_in.rot_valid = dvalid_ff;
               rsp_word_in.angle     = angle_ff;
               rsp_word_in.speed     = speed_ff;
               state_in              = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         angle_ff     <= '0;
         speed_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         angle_ff     <= angle_in;
         speed_ff     <= speed_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      tbl_ff      <= tbl_in;
      prod_ff     <= prod_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      qest_ff     <= qest_in;
      q_ff        <= q_in;
      rnz_ff      <= rnz_in;
      ta_ff       <= ta_in;
      ts_ff       <= ts_in;
      ss_ff       <= ss_in;
      drive_ff    <= drive_in;
      dvalid_ff   <= dvalid_in;
      rsp_word_ff <= rsp_word_in;
   end

endmodule

// ===== rtl/turret_aim_interpolator_top.sv =====
// Top level of the turret aim interpolator: register port, front end, queue and back end
//
// Request stream (req_*): one word per camera frame or operator nudge; tuser carries
// the mode (frame, angle nudge, speed nudge). Response stream (rsp_*): exactly one
// word per request, in order, with the turret drive, the smoothed shooter angle and
// the smoothed shooter speed after that request.
// Requests are classified on entry (drive operand, ty segment) and wait in a
// two-entry queue; the back end works on one at a time through a single shared
// 35x24 multiplier, one product per cycle.
// A nudge passes through the NUDGE and DONE states. A frame with drive and table update
// passes through DRV and DRVC, then a table lookup for angle and one for speed (each
// LKN, LKQ, LKM, LKE, LKC and LKA on an interior segment, LKN alone at a flat end),
// then SMA, SMS, SMW and DONE. The back end starts the next request only after the last one's response is registered.
// A stalled response holds in the output register while the back end completes the
// next word; req_tready falls whenever the queue is full.
// Reset (synchronous, active high) zeroes angle and speed, empties the queue, drops
// rsp_tvalid and loads the register defaults. Registers sit at byte offsets 0, 4, 8
// and 12: track gain, home gain, angle minimum, angle maximum; write them only idle.
module turret_aim_interpolator_top import tai_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // offset_x, offset_y, target_seen, turret_position, yaw_enable,
   // pitch_enable, nudge_rate, zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // mode
   input  logic [MODE_W-1:0]     req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // rotate_drive, shooter_angle, shooter_speed, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // rotate_valid
   output logic                  rsp_tuser,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [3:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam logic [1:0] REG_GAIN_TRACK = 2'd0;
   localparam logic [1:0] REG_GAIN_HOME  = 2'd1;
   localparam logic [1:0] REG_ANGLE_MIN  = 2'd2;
   localparam logic [1:0] REG_ANGLE_MAX  = 2'd3;

   cfg_type    cfg_ff, cfg_in;
   logic       cfg_wr;
   logic       push;
   item_type   push_item;
   logic       q_full;
   logic       q_empty;
   logic       q_pop;
   item_type   q_head;
   result_type rsp_word;

   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_wr) begin
         case (csr_paddr[3:2])
            REG_GAIN_TRACK: cfg_in.gain_track = csr_pwdata[GAIN_W-1:0];
            REG_GAIN_HOME:  cfg_in.gain_home  = csr_pwdata[GAIN_W-1:0];
            REG_ANGLE_MIN:  cfg_in.angle_min  = csr_pwdata[ANGLE_W-1:0];
            REG_ANGLE_MAX:  cfg_in.angle_max  = csr_pwdata[ANGLE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_GAIN_TRACK: csr_prdata = 32'(cfg_ff.gain_track);
         REG_GAIN_HOME:  csr_prdata = 32'(cfg_ff.gain_home);
         REG_ANGLE_MIN:  csr_prdata = 32'(cfg_ff.angle_min);
         REG_ANGLE_MAX:  csr_prdata = 32'(cfg_ff.angle_max);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_track <= 16'd3277;
         cfg_ff.gain_home  <= 16'd524;
         cfg_ff.angle_min  <= 16'sd0;
         cfg_ff.angle_max  <= 16'sd8192;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tai_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (q_full),
      .push       (push),
      .push_item  (push_item)
   );

   tai_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   tai_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_empty    (q_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_word   (rsp_word)
   );

   assign rsp_tdata = {{(RSP_DATA_W - RSP_USED_W){1'b0}},
                       rsp_word.speed, rsp_word.angle, rsp_word.drive};
   assign rsp_tuser = rsp_word.rot_valid;

endmodule

// ===== rtl/tai_checker.sv =====
// Port-level checks for the turret aim interpolator, bound to the top level
module tai_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic        rsp_tuser
);

   // no response survives reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // a stalled response word holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response word changed");

   // drive stays within plus or minus one
   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[9:0]) <= 10'sd256 &&
                      $signed(rsp_tdata[9:0]) >= -10'sd256))
      else $error("rotate drive out of range");

   // drive is zero when not computed
   a_drive_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[9:0] == 10'd0)
      else $error("rotate drive set without rotate valid");

endmodule

bind turret_aim_interpolator_top tai_checker u_tai_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
